>>> design/ccr_pkg.sv
package ccr_pkg;

   // Field widths of the interface.
   localparam int CCR_COORD_W = 12;
   localparam int CCR_PIX_W   = 8;
   localparam int CCR_THR_W   = 18;
   localparam int CCR_MODE_W  = 2;
   localparam int CCR_IDX_W   = 2;
   localparam int CCR_RESP_W  = 20;

   // Internal arithmetic widths.
   localparam int CCR_BASE_W    = 18;
   localparam int CCR_NUM_W     = 36;
   localparam int CCR_DEN_W     = 20;
   localparam int CCR_DIV_STEPS = 20;
   localparam int CCR_RAD_W     = 38;
   localparam int CCR_ROOT_W    = 19;

   // Operating modes. The unused value behaves as the simple mode.
   localparam logic [CCR_MODE_W-1:0] MODE_SIMPLE   = 2'd0;
   localparam logic [CCR_MODE_W-1:0] MODE_LINEAR   = 2'd1;
   localparam logic [CCR_MODE_W-1:0] MODE_CIRCULAR = 2'd2;
   localparam logic [CCR_MODE_W-1:0] MODE_UNUSED   = 2'd3;

   // Register indexes.
   localparam logic [CCR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CCR_IDX_W-1:0] CSR_COARSE = 2'd1;
   localparam logic [CCR_IDX_W-1:0] CSR_FINE   = 2'd2;

   typedef enum logic [1:0] {
      SEL_DIRECT,
      SEL_LINEAR,
      SEL_CIRCULAR
   } ccr_sel_type;

   typedef struct packed {
      logic [CCR_COORD_W-1:0] column;
      logic [CCR_COORD_W-1:0] row;
      logic [CCR_PIX_W-1:0]   center_pixel;
      logic [CCR_PIX_W-1:0]   east_pixel;
      logic [CCR_PIX_W-1:0]   west_pixel;
      logic [CCR_PIX_W-1:0]   north_pixel;
      logic [CCR_PIX_W-1:0]   south_pixel;
   } ccr_req_type;

   typedef struct packed {
      logic [CCR_COORD_W-1:0]       out_column;
      logic [CCR_COORD_W-1:0]       out_row;
      logic                         is_corner;
      logic signed [CCR_RESP_W-1:0] response_doubled;
   } ccr_rsp_type;

   typedef struct packed {
      logic [CCR_MODE_W-1:0] mode;
      logic [CCR_THR_W-1:0]  coarse_threshold;
      logic [CCR_THR_W-1:0]  fine_threshold;
   } ccr_cfg_type;

   typedef struct packed {
      logic [CCR_COORD_W-1:0] column;
      logic [CCR_COORD_W-1:0] row;
      logic                   is_corner;
      ccr_sel_type            sel;
      logic [CCR_BASE_W-1:0]  base;
   } ccr_side_type;

   typedef struct packed {
      logic [CCR_NUM_W-1:0] num;
      logic [CCR_DEN_W-1:0] den;
      logic [CCR_RAD_W-1:0] rad;
   } ccr_op_type;

endpackage

>>> design/ccr_front.sv
module ccr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  ccr_pkg::ccr_req_type in_data,
   input  ccr_pkg::ccr_cfg_type cfg,
   output logic                 out_valid,
   output ccr_pkg::ccr_side_type out_side,
   output ccr_pkg::ccr_op_type  out_op
);
   import ccr_pkg::*;

   // Stage 1: pixel differences, cross operands chosen by mode.
   logic signed [8:0] dac_w, dapc_w, dbc_w, dbpc_w, dba_w, dbpap_w, dbap_w, dbpa_w;
   logic signed [8:0] s1_xa_in [4];
   logic signed [8:0] s1_xb_in [4];
   logic signed [8:0] s1_xa_ff [4];
   logic signed [8:0] s1_xb_ff [4];
   logic signed [8:0] s1_dac_ff, s1_dapc_ff, s1_dbc_ff, s1_dbpc_ff;
   logic [CCR_COORD_W-1:0] s1_col_ff, s1_row_ff;
   logic s1_v_ff;

   always_comb begin
      dac_w   = $signed({1'b0, in_data.east_pixel})  - $signed({1'b0, in_data.center_pixel});
      dapc_w  = $signed({1'b0, in_data.west_pixel})  - $signed({1'b0, in_data.center_pixel});
      dbc_w   = $signed({1'b0, in_data.north_pixel}) - $signed({1'b0, in_data.center_pixel});
      dbpc_w  = $signed({1'b0, in_data.south_pixel}) - $signed({1'b0, in_data.center_pixel});
      dba_w   = $signed({1'b0, in_data.north_pixel}) - $signed({1'b0, in_data.east_pixel});
      dbpap_w = $signed({1'b0, in_data.south_pixel}) - $signed({1'b0, in_data.west_pixel});
      dbap_w  = $signed({1'b0, in_data.north_pixel}) - $signed({1'b0, in_data.west_pixel});
      dbpa_w  = $signed({1'b0, in_data.south_pixel}) - $signed({1'b0, in_data.east_pixel});
      if (cfg.mode == MODE_LINEAR) begin
         s1_xa_in[0] = dba_w;   s1_xb_in[0] = dac_w;
         s1_xa_in[1] = dbpap_w; s1_xb_in[1] = dapc_w;
         s1_xa_in[2] = dbap_w;  s1_xb_in[2] = dapc_w;
         s1_xa_in[3] = dbpa_w;  s1_xb_in[3] = dac_w;
      end else begin
         s1_xa_in[0] = dac_w;   s1_xb_in[0] = dbc_w;
         s1_xa_in[1] = dapc_w;  s1_xb_in[1] = dbpc_w;
         s1_xa_in[2] = dapc_w;  s1_xb_in[2] = dbc_w;
         s1_xa_in[3] = dac_w;   s1_xb_in[3] = dbpc_w;
      end
   end

   always_ff @(posedge clock) begin
      s1_dac_ff  <= dac_w;
      s1_dapc_ff <= dapc_w;
      s1_dbc_ff  <= dbc_w;
      s1_dbpc_ff <= dbpc_w;
      s1_xa_ff   <= s1_xa_in;
      s1_xb_ff   <= s1_xb_in;
      s1_col_ff  <= in_data.column;
      s1_row_ff  <= in_data.row;
   end

   // Stage 2: squares and cross products.
   logic signed [17:0] p_ac, p_apc, p_bc, p_bpc;
   logic signed [17:0] s2_x_in [4];
   logic signed [17:0] s2_x_ff [4];
   logic [15:0] s2_sqac_ff, s2_sqapc_ff, s2_sqbc_ff, s2_sqbpc_ff;
   logic [CCR_COORD_W-1:0] s2_col_ff, s2_row_ff;
   logic s2_v_ff;

   always_comb begin
      p_ac  = s1_dac_ff * s1_dac_ff;
      p_apc = s1_dapc_ff * s1_dapc_ff;
      p_bc  = s1_dbc_ff * s1_dbc_ff;
      p_bpc = s1_dbpc_ff * s1_dbpc_ff;
      for (int i = 0; i < 4; i++) begin
         s2_x_in[i] = s1_xa_ff[i] * s1_xb_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      s2_sqac_ff  <= p_ac[15:0];
      s2_sqapc_ff <= p_apc[15:0];
      s2_sqbc_ff  <= p_bc[15:0];
      s2_sqbpc_ff <= p_bpc[15:0];
      s2_x_ff     <= s2_x_in;
      s2_col_ff   <= s1_col_ff;
      s2_row_ff   <= s1_row_ff;
   end

   // Stage 3: the two responses and the two cross terms.
   logic [16:0] s3_ra_in, s3_rb_in, s3_ra_ff, s3_rb_ff;
   logic signed [18:0] s3_b1_in, s3_b2_in, s3_b1_ff, s3_b2_ff;
   logic [CCR_COORD_W-1:0] s3_col_ff, s3_row_ff;
   logic s3_v_ff;

   always_comb begin
      s3_ra_in = {1'b0, s2_sqac_ff} + {1'b0, s2_sqapc_ff};
      s3_rb_in = {1'b0, s2_sqbc_ff} + {1'b0, s2_sqbpc_ff};
      s3_b1_in = {s2_x_ff[0][17], s2_x_ff[0]} + {s2_x_ff[1][17], s2_x_ff[1]};
      s3_b2_in = {s2_x_ff[2][17], s2_x_ff[2]} + {s2_x_ff[3][17], s2_x_ff[3]};
   end

   always_ff @(posedge clock) begin
      s3_ra_ff  <= s3_ra_in;
      s3_rb_ff  <= s3_rb_in;
      s3_b1_ff  <= s3_b1_in;
      s3_b2_ff  <= s3_b2_in;
      s3_col_ff <= s2_col_ff;
      s3_row_ff <= s2_row_ff;
   end

   // Stage 4: minimums, refinement terms and threshold margins.
   logic [16:0] r_w;
   logic signed [18:0] s4_bm_in, s4_bm_ff;
   logic signed [20:0] s4_am_in, s4_am_ff, s4_amb_in, s4_amb_ff, s4_d_in, s4_d_ff;
   logic signed [17:0] s4_df_in, s4_df_ff;
   logic signed [18:0] s4_rat_in, s4_rat_ff;
   logic s4_fine_in, s4_fine_ff, s4_coarse_in, s4_coarse_ff;
   logic [CCR_BASE_W-1:0] s4_bdir_in, s4_bdir_ff, s4_blin_in, s4_blin_ff;
   logic [CCR_BASE_W-1:0] s4_bcir_in, s4_bcir_ff;
   logic [CCR_COORD_W-1:0] s4_col_ff, s4_row_ff;
   logic s4_v_ff;

   always_comb begin
      r_w          = (s3_ra_ff < s3_rb_ff) ? s3_ra_ff : s3_rb_ff;
      s4_bm_in     = (s3_b1_ff < s3_b2_ff) ? s3_b1_ff : s3_b2_ff;
      s4_am_in     = $signed({4'b0, s3_rb_ff}) - $signed({4'b0, s3_ra_ff})
                   - {s4_bm_in[18], s4_bm_in, 1'b0};
      s4_amb_in    = $signed({4'b0, s3_rb_ff}) - $signed({4'b0, s3_ra_ff})
                   - {{2{s4_bm_in[18]}}, s4_bm_in};
      s4_df_in     = $signed({1'b0, s3_ra_ff}) - $signed({1'b0, s3_rb_ff});
      s4_d_in      = $signed({4'b0, s3_ra_ff}) + $signed({4'b0, s3_rb_ff})
                   - $signed({2'b0, cfg.fine_threshold, 1'b0});
      s4_rat_in    = $signed({2'b0, s3_ra_ff}) - $signed({1'b0, cfg.fine_threshold});
      s4_fine_in   = {1'b0, r_w} > cfg.fine_threshold;
      s4_coarse_in = {1'b0, r_w} > cfg.coarse_threshold;
      s4_bdir_in   = {r_w, 1'b0};
      s4_blin_in   = {s3_ra_ff, 1'b0};
      s4_bcir_in   = {1'b0, s3_ra_ff} + {1'b0, s3_rb_ff};
   end

   always_ff @(posedge clock) begin
      s4_bm_ff     <= s4_bm_in;
      s4_am_ff     <= s4_am_in;
      s4_amb_ff    <= s4_amb_in;
      s4_df_ff     <= s4_df_in;
      s4_d_ff      <= s4_d_in;
      s4_rat_ff    <= s4_rat_in;
      s4_fine_ff   <= s4_fine_in;
      s4_coarse_ff <= s4_coarse_in;
      s4_bdir_ff   <= s4_bdir_in;
      s4_blin_ff   <= s4_blin_in;
      s4_bcir_ff   <= s4_bcir_in;
      s4_col_ff    <= s3_col_ff;
      s4_row_ff    <= s3_row_ff;
   end

   // Stage 5: the squares and products behind the corner tests.
   logic signed [37:0] p_bm;
   logic signed [35:0] p_df;
   logic signed [39:0] s5_ratam_in, s5_ratam_ff;
   logic signed [41:0] p_d;
   logic [34:0] s5_bmsq_ff, s5_dfsq_ff;
   logic [38:0] s5_dsq_ff;
   logic s5_lin_in, s5_lin_ff, s5_cir_ff, s5_dpos_in, s5_dpos_ff;
   logic s5_fine_ff, s5_coarse_ff;
   logic [CCR_DEN_W-1:0] s5_am_ff;
   logic [CCR_BASE_W-1:0] s5_bdir_ff, s5_blin_ff, s5_bcir_ff;
   logic [CCR_COORD_W-1:0] s5_col_ff, s5_row_ff;
   logic s5_v_ff;

   always_comb begin
      p_bm        = s4_bm_ff * s4_bm_ff;
      p_df        = s4_df_ff * s4_df_ff;
      s5_ratam_in = s4_rat_ff * s4_am_ff;
      p_d         = s4_d_ff * s4_d_ff;
      s5_lin_in   = s4_bm_ff[18] && !s4_amb_ff[20] && (s4_amb_ff != '0);
      s5_dpos_in  = !s4_d_ff[20] && (s4_d_ff != '0);
   end

   always_ff @(posedge clock) begin
      s5_bmsq_ff   <= p_bm[34:0];
      s5_dfsq_ff   <= p_df[34:0];
      s5_ratam_ff  <= s5_ratam_in;
      s5_dsq_ff    <= p_d[38:0];
      s5_lin_ff    <= s5_lin_in;
      s5_cir_ff    <= s4_bm_ff[18];
      s5_dpos_ff   <= s5_dpos_in;
      s5_fine_ff   <= s4_fine_ff;
      s5_coarse_ff <= s4_coarse_ff;
      s5_am_ff     <= s4_am_ff[CCR_DEN_W-1:0];
      s5_bdir_ff   <= s4_bdir_ff;
      s5_blin_ff   <= s4_blin_ff;
      s5_bcir_ff   <= s4_bcir_ff;
      s5_col_ff    <= s4_col_ff;
      s5_row_ff    <= s4_row_ff;
   end

   // Stage 6: dividend, radicand and the linear corner test.
   logic [CCR_NUM_W-1:0] s6_num_in, s6_num_ff;
   logic [CCR_RAD_W-1:0] s6_rad_in, s6_rad_ff;
   logic s6_lingt_in, s6_lingt_ff;
   logic [38:0] s6_dsq_ff;
   logic s6_lin_ff, s6_cir_ff, s6_dpos_ff, s6_fine_ff, s6_coarse_ff;
   logic [CCR_DEN_W-1:0] s6_am_ff;
   logic [CCR_BASE_W-1:0] s6_bdir_ff, s6_blin_ff, s6_bcir_ff;
   logic [CCR_COORD_W-1:0] s6_col_ff, s6_row_ff;
   logic s6_v_ff;

   always_comb begin
      s6_num_in   = {s5_bmsq_ff, 1'b0};
      s6_rad_in   = {3'b0, s5_dfsq_ff} + {1'b0, s5_bmsq_ff, 2'b00};
      s6_lingt_in = s5_ratam_ff > $signed({5'b0, s5_bmsq_ff});
   end

   always_ff @(posedge clock) begin
      s6_num_ff    <= s6_num_in;
      s6_rad_ff    <= s6_rad_in;
      s6_lingt_ff  <= s6_lingt_in;
      s6_dsq_ff    <= s5_dsq_ff;
      s6_lin_ff    <= s5_lin_ff;
      s6_cir_ff    <= s5_cir_ff;
      s6_dpos_ff   <= s5_dpos_ff;
      s6_fine_ff   <= s5_fine_ff;
      s6_coarse_ff <= s5_coarse_ff;
      s6_am_ff     <= s5_am_ff;
      s6_bdir_ff   <= s5_bdir_ff;
      s6_blin_ff   <= s5_blin_ff;
      s6_bcir_ff   <= s5_bcir_ff;
      s6_col_ff    <= s5_col_ff;
      s6_row_ff    <= s5_row_ff;
   end

   // Stage 7: circular corner test and the final decision.
   ccr_side_type s7_side_in, s7_side_ff;
   ccr_op_type   s7_op_in, s7_op_ff;
   logic s7_v_ff;
   logic cirgt_w;

   always_comb begin
      cirgt_w              = s6_dpos_ff && (s6_dsq_ff > {1'b0, s6_rad_ff});
      s7_side_in.column    = s6_col_ff;
      s7_side_in.row       = s6_row_ff;
      s7_side_in.is_corner = 1'b0;
      s7_side_in.sel       = SEL_DIRECT;
      s7_side_in.base      = s6_bdir_ff;
      if (cfg.mode == MODE_LINEAR || cfg.mode == MODE_CIRCULAR) begin
         if (s6_fine_ff) begin
            s7_side_in.is_corner = 1'b1;
            if (cfg.mode == MODE_LINEAR && s6_lin_ff) begin
               s7_side_in.sel       = SEL_LINEAR;
               s7_side_in.base      = s6_blin_ff;
               s7_side_in.is_corner = s6_lingt_ff;
            end else if (cfg.mode == MODE_CIRCULAR && s6_cir_ff) begin
               s7_side_in.sel       = SEL_CIRCULAR;
               s7_side_in.base      = s6_bcir_ff;
               s7_side_in.is_corner = cirgt_w;
            end
         end
      end else begin
         s7_side_in.is_corner = s6_coarse_ff;
      end
      s7_op_in.num = s6_num_ff;
      s7_op_in.den = s6_am_ff;
      s7_op_in.rad = s6_rad_ff;
   end

   always_ff @(posedge clock) begin
      s7_side_ff <= s7_side_in;
      s7_op_ff   <= s7_op_in;
   end

   // Valid bits travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
      end
   end

   assign out_valid = s7_v_ff;
   assign out_side  = s7_side_ff;
   assign out_op    = s7_op_ff;

endmodule

>>> design/ccr_div.sv
module ccr_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic [ccr_pkg::CCR_NUM_W-1:0]        dividend,
   input  logic [ccr_pkg::CCR_DEN_W-1:0]        divisor,
   output logic                                 out_valid,
   output logic [ccr_pkg::CCR_DIV_STEPS-1:0]    quotient,
   output logic                                 rem_nonzero
);
   import ccr_pkg::*;

   // One quotient bit per stage, restoring division.
   logic                     v_ff   [CCR_DIV_STEPS];
   logic [CCR_DEN_W-1:0]     rem_ff [CCR_DIV_STEPS];
   logic [CCR_DIV_STEPS-1:0] low_ff [CCR_DIV_STEPS];
   logic [CCR_DIV_STEPS-1:0] quo_ff [CCR_DIV_STEPS];
   logic [CCR_DEN_W-1:0]     dvs_ff [CCR_DIV_STEPS];

   for (genvar k = 0; k < CCR_DIV_STEPS; k++) begin : g_step
      logic                     v_src;
      logic [CCR_DEN_W-1:0]     rem_src, dvs_src, rem_in;
      logic [CCR_DIV_STEPS-1:0] low_src, quo_src, quo_in;
      logic [CCR_DEN_W:0]       trial;

      if (k == 0) begin : g_first
         assign v_src   = in_valid;
         assign rem_src = CCR_DEN_W'(dividend >> CCR_DIV_STEPS);
         assign low_src = dividend[CCR_DIV_STEPS-1:0];
         assign quo_src = '0;
         assign dvs_src = divisor;
      end else begin : g_next
         assign v_src   = v_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign low_src = low_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign dvs_src = dvs_ff[k-1];
      end

      always_comb begin
         trial = {rem_src, low_src[CCR_DIV_STEPS-1]};
         if (trial >= {1'b0, dvs_src}) begin
            rem_in = CCR_DEN_W'(trial - {1'b0, dvs_src});
            quo_in = {quo_src[CCR_DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_in = trial[CCR_DEN_W-1:0];
            quo_in = {quo_src[CCR_DIV_STEPS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         low_ff[k] <= {low_src[CCR_DIV_STEPS-2:0], 1'b0};
         quo_ff[k] <= quo_in;
         dvs_ff[k] <= dvs_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_src;
         end
      end
   end

   assign out_valid   = v_ff[CCR_DIV_STEPS-1];
   assign quotient    = quo_ff[CCR_DIV_STEPS-1];
   assign rem_nonzero = |rem_ff[CCR_DIV_STEPS-1];

endmodule

>>> design/ccr_sqrt.sv
module ccr_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [ccr_pkg::CCR_RAD_W-1:0]     radicand,
   output logic                              out_valid,
   output logic [ccr_pkg::CCR_ROOT_W-1:0]    root,
   output logic                              rem_nonzero
);
   import ccr_pkg::*;

   localparam int REM_W = CCR_ROOT_W + 2;

   // One root bit per stage; a final register matches the divider latency.
   logic                  v_ff    [CCR_ROOT_W];
   logic [REM_W-1:0]      rem_ff  [CCR_ROOT_W];
   logic [CCR_ROOT_W-1:0] root_ff [CCR_ROOT_W];
   logic [CCR_RAD_W-1:0]  rad_ff  [CCR_ROOT_W];

   for (genvar k = 0; k < CCR_ROOT_W; k++) begin : g_step
      logic                  v_src;
      logic [REM_W-1:0]      rem_src, rem_in;
      logic [CCR_ROOT_W-1:0] root_src, root_in;
      logic [CCR_RAD_W-1:0]  rad_src;
      logic [REM_W+1:0]      trial_rem;
      logic [REM_W+1:0]      trial;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = radicand;
      end else begin : g_next
         assign v_src    = v_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
      end

      always_comb begin
         trial_rem = {rem_src, rad_src[CCR_RAD_W-1 -: 2]};
         trial     = {1'b0, root_src, 2'b01};
         if (trial_rem >= trial) begin
            rem_in  = REM_W'(trial_rem - trial);
            root_in = {root_src[CCR_ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = trial_rem[REM_W-1:0];
            root_in = {root_src[CCR_ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= {rad_src[CCR_RAD_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_src;
         end
      end
   end

   logic                  out_v_ff;
   logic [CCR_ROOT_W-1:0] out_root_ff;
   logic                  out_nz_ff;

   always_ff @(posedge clock) begin
      out_root_ff <= root_ff[CCR_ROOT_W-1];
      out_nz_ff   <= |rem_ff[CCR_ROOT_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= v_ff[CCR_ROOT_W-1];
      end
   end

   assign out_valid   = out_v_ff;
   assign root        = out_root_ff;
   assign rem_nonzero = out_nz_ff;

endmodule

>>> design/cross_corner_response_top.sv
// Path: the front end, then the divider and the square root unit side by side, then an output register.
// Throughput: one item per clock; the 20-stage divider and the 20-stage square root
// unit are fully pipelined, so start may stay high in every cycle.
// Reset clears the pipeline valid bits and sets mode to 1 and both thresholds to 0.
// The receiver cannot stall, so busy stays low and every item flows straight through.
module cross_corner_response_top #(
   parameter int MAX_COLUMNS = 4096,
   parameter int MAX_ROWS    = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ccr_pkg::ccr_req_type              req_data,
   output logic                              rsp_valid,
   output ccr_pkg::ccr_rsp_type              rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ccr_pkg::CCR_IDX_W-1:0]     csr_index,
   input  logic [ccr_pkg::CCR_THR_W-1:0]     csr_wdata
);
   import ccr_pkg::*;

   localparam int LATENCY = 7 + CCR_DIV_STEPS + 1;

   // Configuration registers. Writes are taken in any cycle; the user must issue
   // them only while the pipeline is empty, so every stage sees stable values; the block does not enforce this.
   ccr_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:   cfg_in.mode             = csr_wdata[CCR_MODE_W-1:0];
            CSR_COARSE: cfg_in.coarse_threshold = csr_wdata;
            CSR_FINE:   cfg_in.fine_threshold   = csr_wdata;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode             <= MODE_LINEAR;
         cfg_ff.coarse_threshold <= '0;
         cfg_ff.fine_threshold   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // Front end: seven stages that form the responses, the refinement terms
   // and the corner decision.
   logic         front_valid;
   ccr_side_type front_side;
   ccr_op_type   front_op;

   ccr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_side  (front_side),
      .out_op    (front_op)
   );

   // The divider serves the linear refinement, the square root the circular
   // one. Both run on every item and have the same latency; the result
   // select below picks the one that applies.
   logic                     div_valid, div_nz;
   logic [CCR_DIV_STEPS-1:0] div_quo;
   logic                     sqrt_valid, sqrt_nz;
   logic [CCR_ROOT_W-1:0]    sqrt_root;

   ccr_div u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (front_valid),
      .dividend    (front_op.num),
      .divisor     (front_op.den),
      .out_valid   (div_valid),
      .quotient    (div_quo),
      .rem_nonzero (div_nz)
   );

   ccr_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (front_valid),
      .radicand    (front_op.rad),
      .out_valid   (sqrt_valid),
      .root        (sqrt_root),
      .rem_nonzero (sqrt_nz)
   );

   // Side information waits alongside the arithmetic units.
   ccr_side_type side_ff [CCR_DIV_STEPS];

   always_ff @(posedge clock) begin
      side_ff[0] <= front_side;
      for (int i = 1; i < CCR_DIV_STEPS; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   // Output stage. A nonzero remainder rounds the quotient or the root up,
   // which rounds the doubled response down.
   ccr_side_type         side_w;
   logic [CCR_RESP_W:0]  resp_w;
   logic                 in_frame_w;
   ccr_rsp_type          rsp_in, rsp_ff;
   logic                 rsp_valid_ff;

   always_comb begin
      side_w = side_ff[CCR_DIV_STEPS-1];
      unique case (side_w.sel)
         SEL_LINEAR:   resp_w = {3'b0, side_w.base} - {1'b0, div_quo}
                              - {{CCR_RESP_W{1'b0}}, div_nz};
         SEL_CIRCULAR: resp_w = {3'b0, side_w.base} - {2'b0, sqrt_root}
                              - {{CCR_RESP_W{1'b0}}, sqrt_nz};
         default:      resp_w = {3'b0, side_w.base};
      endcase
      in_frame_w = (32'(side_w.column) < 32'(MAX_COLUMNS))
                && (32'(side_w.row) < 32'(MAX_ROWS));
      rsp_in.out_column       = side_w.column;
      rsp_in.out_row          = side_w.row;
      rsp_in.is_corner        = side_w.is_corner && in_frame_w;
      rsp_in.response_doubled = resp_w[CCR_RESP_W-1:0];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching item");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("item taken but no result delivered");

   a_units_aligned: assert property (@(posedge clock) disable iff (reset)
      div_valid == sqrt_valid)
      else $error("divider and square root out of step");

   a_frame_gate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (32'(rsp_data.out_column) >= 32'(MAX_COLUMNS)))
         |-> !rsp_data.is_corner)
      else $error("corner flagged outside the frame");
`endif

endmodule
